@@ design/iphpc_pkg.sv @@
// Package for the IPv4 header parse and check block.
// Holds the queue entry type, item kinds, status codes, sizes and the minimum IHL; no dependencies.
package iphpc_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int POS_W = 6;
  localparam logic [3:0] MIN_IHL = 4'd5;

  typedef enum logic [1:0] {
    ITEM_PASS  = 2'd0,
    ITEM_DONE  = 2'd1,
    ITEM_SHORT = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_BAD_IHL  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [POS_W-1:0] pos;
    item_kind_t       kind;
  } entry_t;

endpackage

@@ design/ipv4_header_parse_check_top.sv @@
// IPv4 header parse and check: top level.
// Ties front end, queue and back end together; uses iphpc_pkg.
//
// Input channel (in_valid/in_ready): one packet byte per item, network order,
// with last on the final byte of the packet. One byte is taken per cycle while in_ready is high.
// Output channel (out_valid/out_ready): one result per packet, carrying the
// fixed header fields and a status (ok, too short, bad header length,
// checksum mismatch). The result leaves as soon as the IHL*4-th header byte
// (or an early last byte) is in; bytes after that up to last are dropped.
// A byte passes through the queue and the result register loads as it leaves,
// so out_valid is registered and rises once the deciding byte leaves the queue.
// Throughput: one byte per cycle while the queue has room; the 16-bit ones'
// complement add in the back end runs once per word. When the receiver stalls, the
// result holds and the queue (QUEUE_DEPTH bytes) fills; in_ready falls once it is full.
// Reset clears position, drain state, queue and captures; no result is valid.
module ipv4_header_parse_check_top
  import iphpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  version,
  output logic [3:0]  header_words,
  output logic [7:0]  type_of_service,
  output logic [15:0] datagram_length,
  output logic [15:0] identification,
  output logic [2:0]  flag_bits,
  output logic [12:0] frag_offset,
  output logic [7:0]  ttl,
  output logic [7:0]  protocol,
  output logic [31:0] source_address,
  output logic [31:0] destination_address
);

  logic   queue_full, push, pop, head_valid;
  entry_t push_entry, head_entry;

  iphpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last       (last),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  iphpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  iphpc_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head_valid          (head_valid),
    .head_entry          (head_entry),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .version             (version),
    .header_words        (header_words),
    .type_of_service     (type_of_service),
    .datagram_length     (datagram_length),
    .identification      (identification),
    .flag_bits           (flag_bits),
    .frag_offset         (frag_offset),
    .ttl                 (ttl),
    .protocol            (protocol),
    .source_address      (source_address),
    .destination_address (destination_address)
  );

endmodule

@@ design/iphpc_front.sv @@
// Front end: tracks byte position, header length and trailing-byte drain.
// Classifies each byte and pushes it to the queue; uses iphpc_pkg.
module iphpc_front
  import iphpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last,
  input  logic       queue_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [POS_W-1:0] byte_count, byte_count_next;
  logic [3:0]       ihl, ihl_next;
  logic             draining, draining_next;
  logic             accept;
  logic [3:0]       ihl_cur;
  logic [POS_W:0]   pos_plus;
  logic [POS_W-1:0] target;
  logic             done;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  assign ihl_cur  = (byte_count == '0) ? data_byte[3:0] : ihl;
  assign target   = {ihl_cur, 2'b00};
  assign pos_plus = {1'b0, byte_count} + 7'd1;
  assign done     = pos_plus >= {1'b0, target};

  always_comb begin
    byte_count_next = byte_count;
    ihl_next        = ihl;
    draining_next   = draining;
    push            = 1'b0;
    push_entry.data_byte = data_byte;
    push_entry.pos       = byte_count;
    push_entry.kind      = ITEM_PASS;
    if (accept) begin
      if (draining) begin
        // drop trailing bytes up to the last mark
        if (last) begin
          draining_next = 1'b0;
        end
      end else begin
        push     = 1'b1;
        ihl_next = ihl_cur;
        if (done) begin
          push_entry.kind = ITEM_DONE;
          byte_count_next = '0;
          draining_next   = !last;
        end else if (last) begin
          push_entry.kind = ITEM_SHORT;
          byte_count_next = '0;
        end else begin
          byte_count_next = pos_plus[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ihl        <= '0;
      draining   <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      ihl        <= ihl_next;
      draining   <= draining_next;
    end
  end

endmodule

@@ design/iphpc_queue.sv @@
// Short register queue between front and back ends.
// Holds classified bytes; uses iphpc_pkg for the entry type.
module iphpc_queue
  import iphpc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = count == CNT_FULL;
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/iphpc_back.sv @@
// Back end: captures header fields, keeps the ones' complement sum, judges status.
// Drives the registered result; uses iphpc_pkg.
module iphpc_back
  import iphpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  version,
  output logic [3:0]  header_words,
  output logic [7:0]  type_of_service,
  output logic [15:0] datagram_length,
  output logic [15:0] identification,
  output logic [2:0]  flag_bits,
  output logic [12:0] frag_offset,
  output logic [7:0]  ttl,
  output logic [7:0]  protocol,
  output logic [31:0] source_address,
  output logic [31:0] destination_address
);

  logic [3:0]  ihl_seen, ihl_seen_next;
  logic [3:0]  version_seen, version_seen_next;
  logic [7:0]  service_seen, service_seen_next;
  logic [15:0] length_seen, length_seen_next;
  logic [15:0] id_seen, id_seen_next;
  logic [15:0] flag_word_seen, flag_word_seen_next;
  logic [7:0]  ttl_seen, ttl_seen_next;
  logic [7:0]  protocol_seen, protocol_seen_next;
  logic [15:0] stored_sum_seen, stored_sum_seen_next;
  logic [31:0] source_seen, source_seen_next;
  logic [31:0] dest_seen, dest_seen_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;

  logic [7:0]       b;
  logic [POS_W-1:0] pos;
  logic             first;
  logic [15:0]      word;
  logic [16:0]      wide_sum;
  logic [15:0]      sum_base;
  logic             emit;
  status_t          status_next;

  assign b     = head_entry.data_byte;
  assign pos   = head_entry.pos;
  assign first = pos == '0;
  assign emit  = head_entry.kind != ITEM_PASS;
  // a result may leave only when the output register is free or being taken
  assign pop   = head_valid && (!emit || !out_valid || out_ready);

  always_comb begin
    // clear every capture at the first byte of a packet
    ihl_seen_next        = first ? '0 : ihl_seen;
    version_seen_next    = first ? '0 : version_seen;
    service_seen_next    = first ? '0 : service_seen;
    length_seen_next     = first ? '0 : length_seen;
    id_seen_next         = first ? '0 : id_seen;
    flag_word_seen_next  = first ? '0 : flag_word_seen;
    ttl_seen_next        = first ? '0 : ttl_seen;
    protocol_seen_next   = first ? '0 : protocol_seen;
    stored_sum_seen_next = first ? '0 : stored_sum_seen;
    source_seen_next     = first ? '0 : source_seen;
    dest_seen_next       = first ? '0 : dest_seen;
    sum_base             = first ? '0 : running_sum;
    high_byte_hold_next  = high_byte_hold;
    running_sum_next     = sum_base;
    word                 = '0;
    wide_sum             = '0;

    case (pos) inside
      6'd0: begin
        version_seen_next = b[7:4];
        ihl_seen_next     = b[3:0];
      end
      6'd1:        service_seen_next    = b;
      [6'd2:6'd3]: length_seen_next     = {length_seen_next[7:0], b};
      [6'd4:6'd5]: id_seen_next         = {id_seen_next[7:0], b};
      [6'd6:6'd7]: flag_word_seen_next  = {flag_word_seen_next[7:0], b};
      6'd8:        ttl_seen_next        = b;
      6'd9:        protocol_seen_next   = b;
      [6'd10:6'd11]: stored_sum_seen_next = {stored_sum_seen_next[7:0], b};
      [6'd12:6'd15]: source_seen_next   = {source_seen_next[23:0], b};
      [6'd16:6'd19]: dest_seen_next     = {dest_seen_next[23:0], b};
      default: ;
    endcase

    if (!pos[0]) begin
      high_byte_hold_next = b;
    end else begin
      // stored checksum word counts as zero
      word             = (pos == 6'd11) ? 16'd0 : {high_byte_hold, b};
      wide_sum         = {1'b0, sum_base} + {1'b0, word};
      running_sum_next = wide_sum[15:0] + {15'd0, wide_sum[16]};
    end

    if (head_entry.kind == ITEM_SHORT) begin
      status_next = ST_SHORT;
    end else if (ihl_seen_next < MIN_IHL) begin
      status_next = ST_BAD_IHL;
    end else if (stored_sum_seen_next != ~running_sum_next) begin
      status_next = ST_MISMATCH;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      ihl_seen        <= '0;
      version_seen    <= '0;
      service_seen    <= '0;
      length_seen     <= '0;
      id_seen         <= '0;
      flag_word_seen  <= '0;
      ttl_seen        <= '0;
      protocol_seen   <= '0;
      stored_sum_seen <= '0;
      source_seen     <= '0;
      dest_seen       <= '0;
      running_sum     <= '0;
      high_byte_hold  <= '0;
    end else begin
      if (pop) begin
        ihl_seen        <= ihl_seen_next;
        version_seen    <= version_seen_next;
        service_seen    <= service_seen_next;
        length_seen     <= length_seen_next;
        id_seen         <= id_seen_next;
        flag_word_seen  <= flag_word_seen_next;
        ttl_seen        <= ttl_seen_next;
        protocol_seen   <= protocol_seen_next;
        stored_sum_seen <= stored_sum_seen_next;
        source_seen     <= source_seen_next;
        dest_seen       <= dest_seen_next;
        running_sum     <= running_sum_next;
        high_byte_hold  <= high_byte_hold_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      status              <= status_next;
      version             <= version_seen_next;
      header_words        <= ihl_seen_next;
      type_of_service     <= service_seen_next;
      datagram_length     <= length_seen_next;
      identification      <= id_seen_next;
      flag_bits           <= flag_word_seen_next[15:13];
      frag_offset         <= flag_word_seen_next[12:0];
      ttl                 <= ttl_seen_next;
      protocol            <= protocol_seen_next;
      source_address      <= source_seen_next;
      destination_address <= dest_seen_next;
    end
  end

endmodule

@@ tb/ipv4_header_parse_check_top_tb.sv @@
// Testbench for ipv4_header_parse_check_top: drives packets byte by byte and
// checks each header result against a cycle-free parser model kept here.
// Depends on iphpc_pkg (status codes, minimum IHL) and the top-level RTL.
`timescale 1ns / 100ps

module ipv4_header_parse_check_top_tb;
  import iphpc_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } link_byte_t;

  typedef struct packed {
    status_t     st;
    logic [3:0]  ver;
    logic [3:0]  words;
    logic [7:0]  tos;
    logic [15:0] len;
    logic [15:0] id;
    logic [2:0]  flags;
    logic [12:0] frag;
    logic [7:0]  hops;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  version;
  logic [3:0]  header_words;
  logic [7:0]  type_of_service;
  logic [15:0] datagram_length;
  logic [15:0] identification;
  logic [2:0]  flag_bits;
  logic [12:0] frag_offset;
  logic [7:0]  ttl;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  ipv4_header_parse_check_top uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .data_byte           (data_byte),
    .last                (last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .status              (status),
    .version             (version),
    .header_words        (header_words),
    .type_of_service     (type_of_service),
    .datagram_length     (datagram_length),
    .identification      (identification),
    .flag_bits           (flag_bits),
    .frag_offset         (frag_offset),
    .ttl                 (ttl),
    .protocol            (protocol),
    .source_address      (source_address),
    .destination_address (destination_address)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  link_byte_t  bytes_to_send [$];
  hdr_result_t hdr_results_due [$];
  logic [7:0]  hdr_buf [60];
  bit          byte_taken;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          results_seen = 0;
  int          status_tally [4] = '{0, 0, 0, 0};

  // parser model state
  logic [5:0]  pkt_pos = '0;
  logic [3:0]  cap_ihl = '0;
  logic [3:0]  cap_version = '0;
  logic [7:0]  cap_tos = '0;
  logic [15:0] cap_len = '0;
  logic [15:0] cap_id = '0;
  logic [15:0] cap_flagword = '0;
  logic [7:0]  cap_ttl = '0;
  logic [7:0]  cap_proto = '0;
  logic [15:0] cap_csum = '0;
  logic [31:0] cap_src = '0;
  logic [31:0] cap_dst = '0;
  logic [15:0] hdr_sum = '0;
  logic [7:0]  even_byte = '0;
  logic        skip_to_last = 1'b0;

  // ones' complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = acc + w;
    return s[15:0] + s[16];
  endfunction

  task automatic clear_capture();
    pkt_pos = '0;
    cap_ihl = '0;
    cap_version = '0;
    cap_tos = '0;
    cap_len = '0;
    cap_id = '0;
    cap_flagword = '0;
    cap_ttl = '0;
    cap_proto = '0;
    cap_csum = '0;
    cap_src = '0;
    cap_dst = '0;
    hdr_sum = '0;
    even_byte = '0;
  endtask

  task automatic push_expect(input status_t st);
    hdr_result_t r;
    r.st = st;
    r.ver = cap_version;
    r.words = cap_ihl;
    r.tos = cap_tos;
    r.len = cap_len;
    r.id = cap_id;
    r.flags = cap_flagword[15:13];
    r.frag = cap_flagword[12:0];
    r.hops = cap_ttl;
    r.proto = cap_proto;
    r.src = cap_src;
    r.dst = cap_dst;
    hdr_results_due.insert(hdr_results_due.size(), r);
    status_tally[st]++;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    int pos;
    int need;
    logic [15:0] word;
    status_t st;
    if (skip_to_last) begin
      if (lst) begin
        skip_to_last = 1'b0;
        clear_capture();
      end
      return;
    end
    if (pkt_pos == 0) clear_capture();
    pos = pkt_pos;
    case (pos)
      0: begin
        cap_version = b[7:4];
        cap_ihl = b[3:0];
      end
      1: cap_tos = b;
      2, 3: cap_len = {cap_len[7:0], b};
      4, 5: cap_id = {cap_id[7:0], b};
      6, 7: cap_flagword = {cap_flagword[7:0], b};
      8: cap_ttl = b;
      9: cap_proto = b;
      10, 11: cap_csum = {cap_csum[7:0], b};
      12, 13, 14, 15: cap_src = {cap_src[23:0], b};
      16, 17, 18, 19: cap_dst = {cap_dst[23:0], b};
      default: ;
    endcase
    // the stored checksum word adds as zero
    if (pos % 2 == 0) begin
      even_byte = b;
    end else begin
      word = (pos == 11) ? 16'h0000 : {even_byte, b};
      hdr_sum = fold_add(hdr_sum, word);
    end
    pkt_pos = 6'(pos + 1);
    need = cap_ihl * 4;
    if (pos + 1 >= need) begin
      if (cap_ihl < MIN_IHL) st = ST_BAD_IHL;
      else if (cap_csum != ~hdr_sum) st = ST_MISMATCH;
      else st = ST_OK;
      push_expect(st);
      pkt_pos = '0;
      // drop the rest of the packet unless this byte ends it
      skip_to_last = !lst;
    end else if (lst) begin
      push_expect(ST_SHORT);
      pkt_pos = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t: %s: got 'h%0h, expected 'h%0h", $time, what, got, want);
  endtask

  task automatic check_result();
    hdr_result_t w;
    if (hdr_results_due.size() == 0) begin
      report_mismatch("result with none pending, status", status, 0);
      return;
    end
    w = hdr_results_due.pop_front();
    results_seen++;
    if (status !== w.st) report_mismatch("status", status, w.st);
    if (version !== w.ver) report_mismatch("version", version, w.ver);
    if (header_words !== w.words) report_mismatch("header_words", header_words, w.words);
    if (type_of_service !== w.tos)
      report_mismatch("type_of_service", type_of_service, w.tos);
    if (datagram_length !== w.len)
      report_mismatch("datagram_length", datagram_length, w.len);
    if (identification !== w.id) report_mismatch("identification", identification, w.id);
    if (flag_bits !== w.flags) report_mismatch("flag_bits", flag_bits, w.flags);
    if (frag_offset !== w.frag) report_mismatch("frag_offset", frag_offset, w.frag);
    if (ttl !== w.hops) report_mismatch("ttl", ttl, w.hops);
    if (protocol !== w.proto) report_mismatch("protocol", protocol, w.proto);
    if (source_address !== w.src) report_mismatch("source_address", source_address, w.src);
    if (destination_address !== w.dst)
      report_mismatch("destination_address", destination_address, w.dst);
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      byte_taken = 1'b0;
      skip_to_last = 1'b0;
      clear_capture();
    end else begin
      byte_taken = in_valid && in_ready;
      if (byte_taken) begin
        bytes_taken++;
        parse_byte(data_byte, last);
      end
      if (out_valid && out_ready) check_result();
    end
  end

  // drive at the falling edge; hold the item until it is taken
  always @(negedge clk) begin
    link_byte_t nb;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || byte_taken) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nb = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          data_byte <= nb.b;
          last <= nb.lst;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    link_byte_t nb;
    nb.b = b;
    nb.lst = lst;
    bytes_to_send.insert(bytes_to_send.size(), nb);
  endtask

  // send the first keep bytes of hdr_buf, then trail filler bytes; last on the final one
  task automatic queue_header(input int hlen, input bit fix_sum, input bit flip,
                              input int keep, input int trail);
    logic [15:0] acc;
    int i;
    int at;
    if (fix_sum) begin
      acc = '0;
      hdr_buf[10] = 8'h00;
      hdr_buf[11] = 8'h00;
      for (i = 0; i < hlen; i += 2) acc = fold_add(acc, {hdr_buf[i], hdr_buf[i+1]});
      {hdr_buf[10], hdr_buf[11]} = ~acc;
    end
    if (flip) begin
      at = $urandom_range(hlen - 1, 1);
      hdr_buf[at] = hdr_buf[at] ^ (8'h01 << $urandom_range(7));
    end
    for (i = 0; i < keep; i++) push_byte(hdr_buf[i], (i == keep - 1) && (trail == 0));
    for (i = 0; i < trail; i++) push_byte(8'($urandom_range(255)), i == trail - 1);
    bytes_queued += keep + trail;
  endtask

  task automatic queue_random_packet();
    int kind;
    int ihl;
    int hlen;
    int keep;
    int trail;
    int i;
    logic [3:0] ver;
    kind = $urandom_range(99);
    for (i = 0; i < 60; i++) hdr_buf[i] = 8'($urandom_range(255));
    // plain noise: random length, random bytes
    if (kind >= 95) begin
      keep = $urandom_range(24, 1);
      queue_header(keep, 1'b0, 1'b0, keep, 0);
      return;
    end
    if (kind < 10) ihl = $urandom_range(4);
    else if ($urandom_range(9) < 6) ihl = 5;
    else if ($urandom_range(3) != 0) ihl = $urandom_range(14, 6);
    else ihl = 15;
    ver = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd4;
    hdr_buf[0] = {ver, 4'(ihl)};
    hlen = (ihl == 0) ? 1 : ihl * 4;
    keep = hlen;
    trail = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
    if (kind >= 25 && kind < 37 && hlen > 1) begin
      keep = $urandom_range(hlen - 1, 1);
      trail = 0;
    end
    queue_header(hlen, ihl >= 5, (ihl >= 5) && kind >= 10 && kind < 25, keep, trail);
  endtask

  task automatic wait_quiet();
    while (bytes_to_send.size() != 0 || in_valid || hdr_results_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int ph;
    int goal;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // IHL zero decides on the first byte
    push_byte(8'h00, 1'b1);
    // IHL one with extreme bytes, then a dropped trailing byte
    push_byte(8'hF1, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b1);
    // last arrives before the header is complete
    push_byte(8'h4F, 1'b0);
    push_byte(8'hFF, 1'b1);
    // full header with every field past version and IHL at an extreme, valid checksum
    hdr_buf = '{default: 8'h00};
    hdr_buf[0] = 8'h45;
    hdr_buf[1] = 8'hFF;
    hdr_buf[2] = 8'hFF;
    hdr_buf[3] = 8'hFF;
    hdr_buf[6] = 8'hFF;
    hdr_buf[7] = 8'hFF;
    hdr_buf[9] = 8'hFF;
    for (int i = 12; i < 16; i++) hdr_buf[i] = 8'hFF;
    queue_header(20, 1'b1, 1'b0, 20, 0);
    wait_quiet();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      goal = bytes_queued + 425;
      while (bytes_queued < goal) queue_random_packet();
      // hold off the sender until every result of this phase is back
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    $display("Parsed %0d bytes into %0d header results over four idle/stall mixes.",
             bytes_taken, results_seen);
    $display("Status mix: ok %0d, too short %0d, bad IHL %0d, checksum mismatch %0d.",
             status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_BAD_IHL],
             status_tally[ST_MISMATCH]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", hdr_results_due.size());
    $display("FAIL");
    $finish;
  end

endmodule
